/* hw/rtl/match_characters_instruction_assert.svh */
// Assertion macros shared by the match-characters checker.
`ifndef MATCH_CHARACTERS_INSTRUCTION_ASSERT_SVH
`define MATCH_CHARACTERS_INSTRUCTION_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define MCI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define MCI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/mci_pkg.sv */
// Shared codes and result word type for the match-characters block.
package mci_pkg;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_FAULT = 2'd2
  } in_kind_t;

  typedef enum logic [1:0] {
    RES_READ  = 2'd0,
    RES_DONE  = 2'd1,
    RES_ABORT = 2'd2
  } res_kind_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [15:0] r0;
    logic [31:0] r1;
    logic [15:0] r2;
    logic [31:0] r3;
    logic        zf;
  } res_t;

endpackage

/* hw/rtl/match_characters_instruction.sv */
// Match-characters sequencer: substring search driven by byte-wide memory reads.
// Each accepted word's result (if any) is registered in the output stage.
// Throughput: one input word per cycle; a two-entry output stage keeps input
//   ready while one result waits to be taken, so only a full skid stalls input.
// Reset (rst, synchronous): sequencer returns to idle, output stage empties.
module match_characters_instruction
  import mci_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [15:0] object_length,
  input  logic [31:0] object_address,
  input  logic [15:0] source_length,
  input  logic [31:0] source_address,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [31:0] read_address,
  output logic [15:0] object_left,
  output logic [31:0] object_pointer_out,
  output logic [15:0] source_left,
  output logic [31:0] source_pointer_out,
  output logic        zero_flag
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_OBJ,
    PH_SRC
  } phase_t;

  // Search state. The attempt registers remember where the current try
  // started in the source, so a mismatch restarts one byte past it.
  // src_end (source address + length) is invariant over the search and
  // gives the final R3 when the object is not found.
  phase_t      phase, phase_next;
  logic [15:0] obj_rem, obj_rem_next;
  logic [31:0] obj_cur, obj_cur_next;
  logic [15:0] src_rem, src_rem_next;
  logic [31:0] src_cur, src_cur_next;
  logic [15:0] obj_total, obj_total_next;
  logic [31:0] obj_base, obj_base_next;
  logic [15:0] att_rem, att_rem_next;
  logic [31:0] att_cur, att_cur_next;
  logic [31:0] src_end, src_end_next;
  logic [7:0]  held, held_next;

  // Candidate registers before the continue/finish decision.
  logic [15:0] c_or, c_sr;
  logic [31:0] c_oc, c_sc, c_end;
  logic        do_adv;
  logic        go_on;
  logic        not_found;

  logic        fire;
  logic        push;
  res_t        res;
  res_t        out_data;

  assign fire = in_valid && in_ready;

  always_comb begin
    phase_next     = phase;
    obj_rem_next   = obj_rem;
    obj_cur_next   = obj_cur;
    src_rem_next   = src_rem;
    src_cur_next   = src_cur;
    obj_total_next = obj_total;
    obj_base_next  = obj_base;
    att_rem_next   = att_rem;
    att_cur_next   = att_cur;
    src_end_next   = src_end;
    held_next      = held;
    c_or           = obj_rem;
    c_oc           = obj_cur;
    c_sr           = src_rem;
    c_sc           = src_cur;
    c_end          = src_end;
    do_adv         = 1'b0;
    push           = 1'b0;
    res            = '0;

    if (fire) begin
      case (kind)
        KIND_START: begin
          // Load a new instruction; drop any running search.
          c_or           = object_length;
          c_oc           = object_address;
          c_sr           = source_length;
          c_sc           = source_address;
          c_end          = source_address + {16'h0000, source_length};
          obj_total_next = object_length;
          obj_base_next  = object_address;
          att_rem_next   = source_length;
          att_cur_next   = source_address;
          src_end_next   = c_end;
          do_adv         = 1'b1;
        end
        KIND_BYTE: begin
          unique case (phase)
            PH_OBJ: begin
              // Hold the object byte, fetch the source byte.
              held_next  = data_byte;
              phase_next = PH_SRC;
              push       = 1'b1;
              res.kind   = RES_READ;
              res.addr   = src_cur;
            end
            PH_SRC: begin
              if (held == data_byte) begin
                // Advance both strings.
                c_or = obj_rem - 16'd1;
                c_oc = obj_cur + 32'd1;
                c_sr = src_rem - 16'd1;
                c_sc = src_cur + 32'd1;
              end else begin
                // Rewind the object, restart one source byte past the attempt.
                c_or         = obj_total;
                c_oc         = obj_base;
                c_sr         = att_rem - 16'd1;
                c_sc         = att_cur + 32'd1;
                att_rem_next = c_sr;
                att_cur_next = c_sc;
              end
              do_adv = 1'b1;
            end
            default: ;  // idle: drop stray bytes
          endcase
        end
        KIND_FAULT: begin
          if (phase != PH_IDLE) begin
            phase_next = PH_IDLE;
            push       = 1'b1;
            res.kind   = RES_ABORT;
          end
        end
        default: ;  // unused code: drop
      endcase
    end

    go_on     = (c_or != 16'd0) && (c_sr >= c_or);
    not_found = c_sr < c_or;

    if (do_adv) begin
      push         = 1'b1;
      obj_rem_next = c_or;
      obj_cur_next = c_oc;
      src_rem_next = c_sr;
      src_cur_next = c_sc;
      if (go_on) begin
        phase_next = PH_OBJ;
        res.kind   = RES_READ;
        res.addr   = c_oc;
      end else begin
        phase_next = PH_IDLE;
        if (not_found) begin
          // Skip the rest of the source.
          src_rem_next = 16'd0;
          src_cur_next = c_end;
        end
        res.kind = RES_DONE;
        res.r0   = c_or;
        res.r1   = c_oc;
        res.r2   = src_rem_next;
        res.r3   = src_cur_next;
        res.zf   = (c_or == 16'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
    obj_rem   <= obj_rem_next;
    obj_cur   <= obj_cur_next;
    src_rem   <= src_rem_next;
    src_cur   <= src_cur_next;
    obj_total <= obj_total_next;
    obj_base  <= obj_base_next;
    att_rem   <= att_rem_next;
    att_cur   <= att_cur_next;
    src_end   <= src_end_next;
    held      <= held_next;
  end

  mci_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign result_kind        = out_data.kind;
  assign read_address       = out_data.addr;
  assign object_left        = out_data.r0;
  assign object_pointer_out = out_data.r1;
  assign source_left        = out_data.r2;
  assign source_pointer_out = out_data.r3;
  assign zero_flag          = out_data.zf;

endmodule

/* hw/rtl/mci_out_buf.sv */
// Two-entry output stage (result register plus skid register).
module mci_out_buf
  import mci_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  output logic can_push,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic main_valid;
  logic skid_valid;
  res_t main_data;
  res_t skid_data;
  logic pop;

  assign pop       = main_valid && out_ready;
  assign can_push  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_data  <= push_data;
        main_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

endmodule

/* hw/rtl/mci_checker.sv */
// Port-level checker for the match-characters block, bound to the top level.
`include "match_characters_instruction_assert.svh"

module mci_checker
  import mci_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  kind,
  input logic [15:0] object_length,
  input logic [31:0] object_address,
  input logic [15:0] source_length,
  input logic [31:0] source_address,
  input logic [7:0]  data_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  result_kind,
  input logic [31:0] read_address,
  input logic [15:0] object_left,
  input logic [31:0] object_pointer_out,
  input logic [15:0] source_left,
  input logic [31:0] source_pointer_out,
  input logic        zero_flag
);

  `MCI_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_kind) && $stable(read_address), "result word changed while stalled")
  `MCI_ASSERT_NOW(a_stall_only_full, !in_ready, out_valid, "input stalled with no result waiting")
  `MCI_ASSERT_NOW(a_kind_legal, out_valid, result_kind != 2'd3, "unused result kind")
  `MCI_ASSERT_NOW(a_done_flag, out_valid && result_kind == RES_DONE, zero_flag == (object_left == 16'd0) && read_address == 32'd0, "done word inconsistent")
  `MCI_ASSERT_NOW(a_read_clean, out_valid && result_kind == RES_READ, object_left == 16'd0 && source_left == 16'd0 && zero_flag == 1'b0, "read word carries final registers")

endmodule

bind match_characters_instruction mci_checker u_mci_checker (.*);
